### design/mttm_pkg.sv
// Package for the multi-timer tick manager: item and result types,
// command codes, sizing constants and the controller/datapath link types.
// Depends on nothing; every other file of the block but mttm_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package mttm_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
    localparam int TICKS_W        = 32;
    localparam int ID_W           = 3;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ARM  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    timer_index;
        logic [TICKS_W-1:0] period_ms;
        logic               reload_enable;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] fired_index;
        logic            last_fired;
    } result_t;

    typedef struct packed {
        logic arm;
        logic clear;
        logic step;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_last;
    } ctrl_status_t;

endpackage

`default_nettype wire

### design/mttm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mttm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/mttm_ctrl.sv
// Controller of the multi-timer tick manager: sequences arm writes and the
// per-tick walk over the timer bank. Depends on mttm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mttm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  cmd,
    input  wire mttm_pkg::ctrl_status_t status,
    output mttm_pkg::ctrl_cmd_t        ctrl,
    output logic                       busy
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == mttm_pkg::CMD_ARM)
                    begin
                        ctrl.arm = 1'b1;
                    end
                    else
                    begin
                        ctrl.clear = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                ctrl.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                ctrl.flush = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // A tick transfer always starts the walk in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == mttm_pkg::CMD_TICK) |=> (state_reg == ST_WALK))
        else $error("tick transfer did not start the walk");

    // The flush state follows the drain state without a gap, and idle follows the flush state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_FLUSH) ##1 (state_reg == ST_IDLE))
        else $error("walk did not finish through drain and flush");

endmodule

`default_nettype wire

### design/mttm_datapath.sv
// Datapath of the multi-timer tick manager: timer storage, the shared
// decrementer and the result staging. Depends on mttm_pkg and mttm_ram.
`timescale 1ns / 1ps
`default_nettype none

module mttm_datapath #(
    parameter int NUM_TIMERS = mttm_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mttm_pkg::item_t     item,
    input  wire mttm_pkg::ctrl_cmd_t ctrl,
    output mttm_pkg::ctrl_status_t   status,
    output logic                     result_valid,
    output mttm_pkg::result_t        result
);

    localparam int IDXW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW     = mttm_pkg::TICKS_W;
    localparam int CNT_W  = mttm_pkg::CNT_W;
    localparam int ID_W   = mttm_pkg::ID_W;

    logic [IDXW-1:0]       walk_idx_reg;
    logic [IDXW-1:0]       walk_idx_next;
    logic                  upd_valid_reg;
    logic [IDXW-1:0]       upd_idx_reg;
    logic [NUM_TIMERS-1:0] en_reg;
    logic [NUM_TIMERS-1:0] en_next;
    logic [NUM_TIMERS-1:0] reload_reg;
    logic [NUM_TIMERS-1:0] reload_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [ID_W-1:0]       pend_idx_reg;
    logic [ID_W-1:0]       pend_idx_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;
    mttm_pkg::result_t     result_reg;
    mttm_pkg::result_t     result_next;

    logic                  arm_ok;
    logic [IDXW-1:0]       arm_addr;
    logic [2*TW-1:0]       rd_data;
    logic [TW-1:0]         rd_period;
    logic [TW-1:0]         rd_rem;
    logic                  upd_live;
    logic                  fire;
    logic                  wr_en;
    logic [IDXW-1:0]       wr_addr;
    logic [2*TW-1:0]       wr_data;

    assign arm_ok    = ctrl.arm && (32'(item.timer_index) < NUM_TIMERS);
    assign arm_addr  = IDXW'(item.timer_index);
    assign rd_period = rd_data[2*TW-1:TW];
    assign rd_rem    = rd_data[TW-1:0];
    assign upd_live  = upd_valid_reg && en_reg[upd_idx_reg];
    assign fire      = upd_live && (rd_rem <= TW'(1));

    assign status.walk_last = (walk_idx_reg == IDXW'(NUM_TIMERS - 1));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = upd_idx_reg;
        wr_data = {rd_period, (rd_rem > TW'(1)) ? (rd_rem - TW'(1)) : rd_period};
        if (arm_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = arm_addr;
            wr_data = {item.period_ms, item.period_ms};
        end
        else if (upd_live)
        begin
            wr_en = 1'b1;
        end
    end

    mttm_ram #(
        .WIDTH (2 * TW),
        .DEPTH (NUM_TIMERS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctrl.step),
        .rd_addr (walk_idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        walk_idx_next     = walk_idx_reg;
        en_next           = en_reg;
        reload_next       = reload_reg;
        pend_valid_next   = pend_valid_reg;
        pend_idx_next     = pend_idx_reg;
        count_next        = count_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        if (ctrl.clear)
        begin
            walk_idx_next   = '0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end
        if (ctrl.step)
        begin
            walk_idx_next = walk_idx_reg + IDXW'(1);
        end
        if (arm_ok)
        begin
            en_next[arm_addr]     = (item.period_ms != '0);
            reload_next[arm_addr] = item.reload_enable;
        end
        if (fire)
        begin
            if (!reload_reg[upd_idx_reg])
            begin
                en_next[upd_idx_reg] = 1'b0;
            end
            if (count_reg < CNT_W'(mttm_pkg::MAX_RESULTS))
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next       = 1'b1;
                    result_next.fired_index = pend_idx_reg;
                    result_next.last_fired  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_idx_next   = ID_W'(upd_idx_reg);
                count_next      = count_reg + CNT_W'(1);
            end
        end
        if (ctrl.flush && pend_valid_reg)
        begin
            result_valid_next       = 1'b1;
            result_next.fired_index = pend_idx_reg;
            result_next.last_fired  = 1'b1;
            pend_valid_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg     <= '0;
            upd_valid_reg    <= 1'b0;
            en_reg           <= '0;
            reload_reg       <= '0;
            pend_valid_reg   <= 1'b0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            walk_idx_reg     <= walk_idx_next;
            upd_valid_reg    <= ctrl.step;
            en_reg           <= en_next;
            reload_reg       <= reload_next;
            pend_valid_reg   <= pend_valid_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_idx_reg  <= walk_idx_reg;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The number of reported expiries never passes the per-tick limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(mttm_pkg::MAX_RESULTS))
        else $error("expiry count exceeded the per-tick limit");

    // The final result of a tick is never followed directly by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.last_fired) |=> !result_valid_reg)
        else $error("result transfer followed the final one of a tick");

endmodule

`default_nettype wire

### design/multi_timer_tick_manager_unit.sv
// Multi-timer tick manager: a bank of NUM_TIMERS millisecond countdown timers with
// optional auto-reload. An arm transfer (cmd = 1) leaves busy low. A tick transfer
// (cmd = 0) walks the bank through one shared decrementer, one timer per cycle out
// of the timer store, and keeps busy high through the walk and the drain and flush
// states, taking no new transfer meanwhile. Each expired timer is reported by a
// one-cycle result_valid strobe, lowest id first, at most eight per tick, with
// last_fired on the final one. The receiver cannot stall: results must be taken in
// the cycle they are shown. Depends on mttm_pkg, mttm_ctrl and mttm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_tick_manager_unit #(
    parameter int NUM_TIMERS = mttm_pkg::NUM_TIMERS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mttm_pkg::item_t   item,
    output logic                   busy,
    output logic                   result_valid,
    output mttm_pkg::result_t      result
);

    mttm_pkg::ctrl_cmd_t    ctrl;
    mttm_pkg::ctrl_status_t status;

    mttm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (item.cmd),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    mttm_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctrl         (ctrl),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for multi_timer_tick_manager_unit: arm and tick commands
// are checked against a cycle-free model of the timer bank, expiry by expiry.
// Depends on mttm_pkg and the multi_timer_tick_manager_unit RTL.
`timescale 1ns / 1ps

module tb;

    localparam int TIMERS        = mttm_pkg::NUM_TIMERS_DEF;
    localparam int ITEMS_TOTAL   = 430;
    localparam int SETTLE_CYCLES = TIMERS + 6;
    localparam int ID_W          = mttm_pkg::ID_W;
    localparam int TICKS_W       = mttm_pkg::TICKS_W;
    localparam int MAX_RESULTS   = mttm_pkg::MAX_RESULTS;

    typedef struct {
        mttm_pkg::item_t payload;
        int unsigned     gap;
        bit              drain;
    } pending_cmd_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    mttm_pkg::item_t   item = '0;
    logic              busy;
    logic              result_valid;
    mttm_pkg::result_t result;

    pending_cmd_t      pending_cmds[$];
    mttm_pkg::result_t expected_fires[$];

    logic [TICKS_W-1:0] timer_count  [TIMERS];
    logic [TICKS_W-1:0] timer_period [TIMERS];
    logic               timer_reload [TIMERS];

    int           accept_count = 0;
    int           sent_count = 0;
    int           fail_count = 0;
    int           cmds_queued = 0;
    bit           loaded = 1'b0;
    pending_cmd_t cur_cmd;
    int unsigned  gap_left = 0;
    int unsigned  settle_left = 0;

    multi_timer_tick_manager_unit #(
        .NUM_TIMERS(TIMERS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .result_valid(result_valid),
        .result      (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    function automatic void advance_timers(input mttm_pkg::item_t it);
        mttm_pkg::result_t batch [MAX_RESULTS];
        int                n;
        if (it.cmd == mttm_pkg::CMD_ARM)
        begin
            if (int'(it.timer_index) < TIMERS)
            begin
                timer_period[it.timer_index] = it.period_ms;
                timer_reload[it.timer_index] = it.reload_enable;
                timer_count[it.timer_index]  = it.period_ms;
            end
            return;
        end
        n = 0;
        for (int i = 0; i < TIMERS; i++)
        begin
            if (timer_period[i] == '0)
                continue;
            if (timer_count[i] > 1)
            begin
                timer_count[i] = timer_count[i] - 1;
                continue;
            end
            timer_count[i] = '0;
            if (n < MAX_RESULTS)
            begin
                batch[n].fired_index = ID_W'(i);
                batch[n].last_fired  = 1'b0;
                n++;
            end
            if (timer_reload[i])
                timer_count[i] = timer_period[i];
            else
                timer_period[i] = '0;
        end
        for (int k = 0; k < n; k++)
        begin
            if (k == n - 1)
                batch[k].last_fired = 1'b1;
            expected_fires.push_back(batch[k]);
        end
    endfunction

    function automatic void queue_cmd(input logic cmd, input logic [ID_W-1:0] idx,
                                      input logic [TICKS_W-1:0] period, input logic reload,
                                      input int unsigned gap, input bit drain);
        pending_cmd_t pc;
        pc.payload.cmd           = cmd;
        pc.payload.timer_index   = idx;
        pc.payload.period_ms     = period;
        pc.payload.reload_enable = reload;
        pc.gap                   = gap;
        pc.drain                 = drain;
        pending_cmds.push_back(pc);
        cmds_queued++;
    endfunction

    function automatic void queue_tick(input int unsigned gap, input bit drain);
        queue_cmd(mttm_pkg::CMD_TICK, ID_W'($urandom_range(0, 7)), $urandom,
                  1'($urandom_range(0, 1)), gap, drain);
    endfunction

    function automatic logic [TICKS_W-1:0] pick_period();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return TICKS_W'($urandom_range(1, 6));
        else if (sel < 80)
            return '0;
        else if (sel < 90)
            return $urandom;
        else
            return 32'hFFFF_FFFF - TICKS_W'($urandom_range(0, 3));
    endfunction

    // Stimulus: directed corners first, then a random mix dominated by short periods so
    // that timers expire often, with bursts of back-to-back transfers.
    initial
    begin
        int unsigned gap;
        bit          drain;
        for (int i = 0; i < TIMERS; i++)
        begin
            timer_count[i]  = '0;
            timer_period[i] = '0;
            timer_reload[i] = 1'b0;
        end
        queue_tick(0, 1'b0);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd0, 32'd1, 1'b0, 1, 1'b0);
        queue_tick(0, 1'b0);
        queue_tick(2, 1'b0);
        for (int i = 0; i < TIMERS; i++)
            queue_cmd(mttm_pkg::CMD_ARM, ID_W'(i), 32'd1, 1'b1, 0, 1'b0);
        queue_tick(0, 1'b0);
        queue_tick(0, 1'b1);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd3, 32'd0, 1'b1, 3, 1'b0);
        queue_tick(1, 1'b0);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd7, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd5, 32'd2, 1'b0, 0, 1'b0);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd6, 32'h8000_0000, 1'b0, 0, 1'b0);
        queue_tick(0, 1'b0);
        queue_tick(0, 1'b0);
        queue_tick(3, 1'b0);
        queue_cmd(mttm_pkg::CMD_ARM, 3'd2, 32'd3, 1'b1, 0, 1'b1);
        queue_tick(0, 1'b0);

        while (cmds_queued < ITEMS_TOTAL)
        begin
            gap   = ((cmds_queued / 40) % 3 == 1) ? 0 : $urandom_range(0, 3);
            drain = (cmds_queued % 150 == 149);
            if ($urandom_range(0, 99) < 55)
                queue_tick(gap, drain);
            else
                queue_cmd(mttm_pkg::CMD_ARM, ID_W'($urandom_range(0, 7)), pick_period(),
                          1'($urandom_range(0, 1)), gap, drain);
        end
    end

    // Driver: presents one transfer at a time and holds it until it has been taken.
    always @(negedge clk)
    begin
        if (rst_n && !(start && accept_count != sent_count))
        begin
            if (!loaded && pending_cmds.size() > 0)
            begin
                cur_cmd     = pending_cmds.pop_front();
                loaded      = 1'b1;
                gap_left    = cur_cmd.gap;
                settle_left = SETTLE_CYCLES;
            end
            if (loaded && cur_cmd.drain
                && (expected_fires.size() != 0 || settle_left != 0))
            begin
                if (expected_fires.size() == 0)
                    settle_left--;
                start <= 1'b0;
            end
            else if (loaded && gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (loaded)
            begin
                start <= 1'b1;
                item  <= cur_cmd.payload;
                sent_count++;
                loaded = 1'b0;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each expiry strobe and feeds every accepted transfer to the model.
    always @(posedge clk)
    begin : monitor
        mttm_pkg::result_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_fires.size() == 0)
                begin
                    $error("unexpected expiry: fired_index %0d, last_fired %0b",
                           result.fired_index, result.last_fired);
                    fail_count++;
                end
                else
                begin
                    want = expected_fires.pop_front();
                    if (result.fired_index !== want.fired_index)
                    begin
                        $error("fired_index mismatch: expected %0d, got %0d",
                               want.fired_index, result.fired_index);
                        fail_count++;
                    end
                    if (result.last_fired !== want.last_fired)
                    begin
                        $error("last_fired mismatch: expected %0b, got %0b",
                               want.last_fired, result.last_fired);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                advance_timers(item);
                accept_count <= accept_count + 1;
            end
        end
    end

    initial
    begin
        wait (rst_n);
        wait (cmds_queued >= ITEMS_TOTAL && accept_count == cmds_queued);
        while (expected_fires.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("multi_timer_tick_manager_unit test passed");
        else
            $display("multi_timer_tick_manager_unit test failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("multi_timer_tick_manager_unit test failed");
        $finish;
    end

endmodule

### files.f
design/mttm_pkg.sv
design/mttm_ram.sv
design/mttm_ctrl.sv
design/mttm_datapath.sv
design/multi_timer_tick_manager_unit.sv
tb/sv/tb.sv
